>>> hdl/adpcm_nd_pkg.sv
// Package: function codes, limits and the step table for the ADPCM nibble decoder.
`default_nettype none

package adpcm_nd_pkg;

    localparam int unsigned FUNC_W    = 2;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned SAMPLE_W  = 16;
    localparam int unsigned INDEX_W   = 7;
    localparam int unsigned STEP_W    = 15;
    localparam int unsigned DIFF_W    = 17;
    localparam int unsigned IN_DATA_W = 32;
    localparam int unsigned IN_USER_W = 3;
    localparam int unsigned OUT_DATA_W = 24;

    localparam logic [INDEX_W-1:0] MAX_INDEX = 7'd88;
    localparam logic signed [SAMPLE_W-1:0] POS_LIMIT = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] NEG_LIMIT = -16'sh7FFF;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_HEADER  = 2'd0,
        FUNC_DECODE  = 2'd1,
        FUNC_RESTORE = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    localparam logic [STEP_W-1:0] STEP_TABLE [0:88] = '{
        15'h0007, 15'h0008, 15'h0009, 15'h000A, 15'h000B, 15'h000C, 15'h000D, 15'h000E,
        15'h0010, 15'h0011, 15'h0013, 15'h0015, 15'h0017, 15'h0019, 15'h001C, 15'h001F,
        15'h0022, 15'h0025, 15'h0029, 15'h002D, 15'h0032, 15'h0037, 15'h003C, 15'h0042,
        15'h0049, 15'h0050, 15'h0058, 15'h0061, 15'h006B, 15'h0076, 15'h0082, 15'h008F,
        15'h009D, 15'h00AD, 15'h00BE, 15'h00D1, 15'h00E6, 15'h00FD, 15'h0117, 15'h0133,
        15'h0151, 15'h0173, 15'h0198, 15'h01C1, 15'h01EE, 15'h0220, 15'h0256, 15'h0292,
        15'h02D4, 15'h031C, 15'h036C, 15'h03C3, 15'h0424, 15'h048E, 15'h0502, 15'h0583,
        15'h0610, 15'h06AB, 15'h0756, 15'h0812, 15'h08E0, 15'h09C3, 15'h0ABD, 15'h0BD0,
        15'h0CFF, 15'h0E4C, 15'h0FBA, 15'h114C, 15'h1307, 15'h14EE, 15'h1706, 15'h1954,
        15'h1BDC, 15'h1EA5, 15'h21B6, 15'h2515, 15'h28CA, 15'h2CDF, 15'h315B, 15'h364B,
        15'h3BB9, 15'h41B2, 15'h4844, 15'h4F7E, 15'h5771, 15'h602F, 15'h69CE, 15'h7462,
        15'h7FFF
    };

    // Index change for the magnitude bits of a nibble.
    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] adj;
        begin
            case (mag)
                3'd4:    adj = 5'sd2;
                3'd5:    adj = 5'sd4;
                3'd6:    adj = 5'sd6;
                3'd7:    adj = 5'sd8;
                default: adj = -5'sd1;
            endcase
            return adj;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/adpcm_nibble_decoder.sv
// Top level: one-channel 4-bit IMA-style ADPCM nibble decoder.
//
// Usage:
//   Input words arrive on the s_axis channel. tuser selects the operation
//   (load header, decode next nibble, restore loop point) and carries the
//   loop mark; tdata carries the data byte, header sample and header index.
//   Every accepted input word yields exactly one output word on m_axis with
//   the sample and step index after the operation and a flag that is set
//   when the byte's high nibble was just consumed.
//   Pipeline: an accepted input word goes into the input register, then
//   through the decode logic into the output register, from which it
//   leaves on m_axis.
//   Throughput: one word per cycle while m_axis_tready stays high; the decode
//   path (step table lookup, step sum, clamped sample and index adds) is combinational.
//   Stall: when m_axis_tready is low the output register holds its word,
//   the input register holds its word, and o_s_axis_tready drops only once
//   the input register is also occupied.
//   Reset: sample, index, nibble select and loop point clear to zero; both
//   pipeline stages empty.
`default_nettype none

module adpcm_nibble_decoder (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_s_axis_tvalid,
    output logic                                       o_s_axis_tready,
    // tdata: data_byte[7:0], header_sample[23:8], header_index[30:24], zero[31]
    input  wire logic [adpcm_nd_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    // tuser: func[1:0], loop_mark[2]
    input  wire logic [adpcm_nd_pkg::IN_USER_W-1:0]    i_s_axis_tuser,
    output logic                                       o_m_axis_tvalid,
    input  wire logic                                  i_m_axis_tready,
    // tdata: sample[15:0], step_index[22:16], advance_byte[23]
    output logic [adpcm_nd_pkg::OUT_DATA_W-1:0]        o_m_axis_tdata
);

    // Input register
    logic                                      r_in_valid;
    adpcm_nd_pkg::t_func                       r_in_func;
    logic [adpcm_nd_pkg::BYTE_W-1:0]           r_in_byte;
    logic signed [adpcm_nd_pkg::SAMPLE_W-1:0]  r_in_hsample;
    logic [adpcm_nd_pkg::INDEX_W-1:0]          r_in_hindex;
    logic                                      r_in_mark;

    // Decoder state
    logic signed [adpcm_nd_pkg::SAMPLE_W-1:0]  r_cur_sample, n_cur_sample;
    logic [adpcm_nd_pkg::INDEX_W-1:0]          r_cur_index, n_cur_index;
    logic                                      r_high_next, n_high_next;
    logic signed [adpcm_nd_pkg::SAMPLE_W-1:0]  r_loop_sample, n_loop_sample;
    logic [adpcm_nd_pkg::INDEX_W-1:0]          r_loop_index, n_loop_index;

    // Output register
    logic                                      r_out_valid;
    logic signed [adpcm_nd_pkg::SAMPLE_W-1:0]  r_out_sample;
    logic [adpcm_nd_pkg::INDEX_W-1:0]          r_out_index;
    logic                                      r_out_adv;
    logic                                      n_adv;

    logic                                      w_process;
    logic                                      w_accept;
    logic [3:0]                                w_nib;
    logic [adpcm_nd_pkg::STEP_W-1:0]           w_step;
    logic [adpcm_nd_pkg::DIFF_W-1:0]           w_diff;
    logic signed [17:0]                        w_sum;
    logic signed [7:0]                         w_idx_sum;
    logic [adpcm_nd_pkg::INDEX_W-1:0]          w_dec_index;
    logic signed [adpcm_nd_pkg::SAMPLE_W-1:0]  w_dec_sample;

    // Move the input word into the output register when that register frees up
    assign w_process = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_process;
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_func    <= adpcm_nd_pkg::t_func'(i_s_axis_tuser[1:0]);
            r_in_mark    <= i_s_axis_tuser[2];
            r_in_byte    <= i_s_axis_tdata[7:0];
            r_in_hsample <= $signed(i_s_axis_tdata[23:8]);
            r_in_hindex  <= i_s_axis_tdata[30:24];
        end
    end

    // Nibble decode: sum of separately truncated step fractions
    always_comb begin
        w_nib  = r_high_next ? r_in_byte[7:4] : r_in_byte[3:0];
        w_step = adpcm_nd_pkg::STEP_TABLE[r_cur_index];
        w_diff = {5'd0, w_step[14:3]};
        if (w_nib[0]) begin
            w_diff = w_diff + {4'd0, w_step[14:2]};
        end
        if (w_nib[1]) begin
            w_diff = w_diff + {3'd0, w_step[14:1]};
        end
        if (w_nib[2]) begin
            w_diff = w_diff + {2'd0, w_step};
        end
        if (w_nib[3]) begin
            w_sum = 18'(r_cur_sample) + $signed({1'b0, w_diff});
            w_dec_sample = (w_sum > 18'(adpcm_nd_pkg::POS_LIMIT))
                ? adpcm_nd_pkg::POS_LIMIT : w_sum[15:0];
        end else begin
            w_sum = 18'(r_cur_sample) - $signed({1'b0, w_diff});
            w_dec_sample = (w_sum < 18'(adpcm_nd_pkg::NEG_LIMIT))
                ? adpcm_nd_pkg::NEG_LIMIT : w_sum[15:0];
        end
        w_idx_sum = $signed({1'b0, r_cur_index})
                  + 8'(adpcm_nd_pkg::index_adjust(w_nib[2:0]));
        if (w_idx_sum < 8'sd0) begin
            w_dec_index = '0;
        end else if (w_idx_sum > $signed({1'b0, adpcm_nd_pkg::MAX_INDEX})) begin
            w_dec_index = adpcm_nd_pkg::MAX_INDEX;
        end else begin
            w_dec_index = w_idx_sum[6:0];
        end
    end

    // Next state per function code
    always_comb begin
        n_cur_sample  = r_cur_sample;
        n_cur_index   = r_cur_index;
        n_high_next   = r_high_next;
        n_loop_sample = r_loop_sample;
        n_loop_index  = r_loop_index;
        n_adv         = 1'b0;
        case (r_in_func)
            adpcm_nd_pkg::FUNC_HEADER: begin
                n_cur_sample = r_in_hsample;
                n_cur_index  = (r_in_hindex > adpcm_nd_pkg::MAX_INDEX)
                             ? adpcm_nd_pkg::MAX_INDEX : r_in_hindex;
                n_high_next  = 1'b0;
            end
            adpcm_nd_pkg::FUNC_DECODE: begin
                n_cur_sample = w_dec_sample;
                n_cur_index  = w_dec_index;
                n_high_next  = !r_high_next;
                n_adv        = r_high_next;
                // Save the loop point when marked, once the whole byte is consumed
                if (r_high_next && r_in_mark) begin
                    n_loop_sample = w_dec_sample;
                    n_loop_index  = w_dec_index;
                end
            end
            adpcm_nd_pkg::FUNC_RESTORE: begin
                n_cur_sample = r_loop_sample;
                n_cur_index  = r_loop_index;
                n_high_next  = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_sample  <= '0;
            r_cur_index   <= '0;
            r_high_next   <= 1'b0;
            r_loop_sample <= '0;
            r_loop_index  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_process) begin
                r_cur_sample  <= n_cur_sample;
                r_cur_index   <= n_cur_index;
                r_high_next   <= n_high_next;
                r_loop_sample <= n_loop_sample;
                r_loop_index  <= n_loop_index;
                r_out_valid   <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            r_out_sample <= n_cur_sample;
            r_out_index  <= n_cur_index;
            r_out_adv    <= n_adv;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_adv, r_out_index, r_out_sample};

    // The step index never leaves the table
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_index <= adpcm_nd_pkg::MAX_INDEX)
        else $error("step index beyond table");

    // A pending output word always matches the live decoder state
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_sample == r_cur_sample && r_out_index == r_cur_index))
        else $error("output word out of step with decoder state");

    // A consumed byte leaves the low nibble selected for the next byte
    a_adv_low_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_adv) |-> !r_high_next)
        else $error("nibble select wrong after byte advance");

    // A waiting input word reaches an empty output register in the next cycle
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("pipeline stalled with free output register");

endmodule

`default_nettype wire
